// ----- sv/bf5_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bf5_pkg
// Shared types and constants of the 5x5 zero-padded box filter.
// ----------------------------------------------------------------------------
package bf5_pkg;

	localparam int PIX_W  = 8;
	localparam int SIZE_W = 10;
	localparam int SUM_W  = 13;
	localparam int MEAN_W = 16;
	localparam int TAPS   = 5;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 10'd64;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	typedef logic [TAPS-1:0][PIX_W-1:0] vec_t;

	typedef struct packed {
		logic              push;
		logic [PIX_W-1:0]  value;
		logic [3:0]        row_mask;
		logic              emit;
		logic [TAPS-1:0]   col_mask;
		logic              last;
	} ctl_t;

endpackage
`default_nettype wire

// ----- sv/bf5_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bf5_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bf5_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ----- sv/bf5_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bf5_ctrl
// Size register and raster counters; decides per transfer whether a column
// is pushed, which taps are masked and whether a result is due.
// ----------------------------------------------------------------------------
module bf5_ctrl #(
	parameter int MAX_SIZE = 512
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [bf5_pkg::SIZE_W-1:0]    cfg_size,
	input  wire logic                          acc,
	input  wire logic                          operation,
	input  wire logic [bf5_pkg::PIX_W-1:0]     pixel_value,
	output      bf5_pkg::ctl_t                 info,
	output      logic [$clog2(MAX_SIZE)-1:0]   col
);

	localparam int CW   = $clog2(MAX_SIZE);
	localparam int NW   = $clog2(MAX_SIZE + 1);
	localparam int RW   = $clog2(MAX_SIZE + 8);
	localparam int LW   = $clog2(2 * MAX_SIZE + 3);
	localparam int CMPW = (NW > bf5_pkg::SIZE_W) ? NW : bf5_pkg::SIZE_W;

	logic [bf5_pkg::SIZE_W-1:0] size_q;
	logic [CW-1:0]              in_col_q;
	logic [RW-1:0]              in_row_q;
	logic [CW-1:0]              out_col_q;
	logic [CW-1:0]              out_row_q;
	logic [LW-1:0]              lead_q;

	logic [CMPW-1:0] n_wide;
	logic [NW-1:0]   n;
	logic [CW-1:0]   n_m1;
	logic [LW-1:0]   lead_tgt;
	logic            draining;
	logic            emit;
	logic            last;

	always_comb begin
		if (CMPW'(size_q) == '0) begin
			n_wide = CMPW'(1);
		end else if (CMPW'(size_q) > CMPW'(MAX_SIZE)) begin
			n_wide = CMPW'(MAX_SIZE);
		end else begin
			n_wide = CMPW'(size_q);
		end
	end

	assign n        = NW'(n_wide);
	assign n_m1     = CW'(n - 1'b1);
	assign lead_tgt = (LW'(n) << 1) + LW'(2);
	assign draining = in_row_q >= RW'(n);
	assign emit     = lead_q == lead_tgt;
	assign last     = (out_row_q == n_m1) && (out_col_q == n_m1);

	always_comb begin
		info.push        = acc && ((operation == bf5_pkg::OP_PIXEL) || draining);
		info.value       = draining ? '0 : pixel_value;
		info.row_mask[0] = in_row_q >= RW'(4);
		info.row_mask[1] = in_row_q >= RW'(3);
		info.row_mask[2] = in_row_q >= RW'(2);
		info.row_mask[3] = in_row_q >= RW'(1);
		info.emit        = emit;
		info.col_mask[0] = out_col_q >= CW'(2);
		info.col_mask[1] = out_col_q >= CW'(1);
		info.col_mask[2] = 1'b1;
		info.col_mask[3] = out_col_q < n_m1;
		info.col_mask[4] = ({1'b0, out_col_q} + (CW + 1)'(2)) <= {1'b0, n_m1};
		info.last        = last;
	end

	assign col = in_col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q    <= bf5_pkg::SIZE_RESET;
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			lead_q    <= '0;
		end else if (cfg_we) begin
			size_q    <= cfg_size;
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			lead_q    <= '0;
		end else if (info.push) begin
			if (in_col_q == n_m1) begin
				in_col_q <= '0;
				in_row_q <= in_row_q + 1'b1;
			end else begin
				in_col_q <= in_col_q + 1'b1;
			end
			if (!emit) begin
				lead_q <= lead_q + 1'b1;
			end else if (last) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
				lead_q    <= '0;
			end else if (out_col_q == n_m1) begin
				out_col_q <= '0;
				out_row_q <= out_row_q + 1'b1;
			end else begin
				out_col_q <= out_col_q + 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ----- sv/bf5_window.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bf5_window
// Five column registers of the 5x5 window and the masked window sum.
// ----------------------------------------------------------------------------
module bf5_window (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         shift,
	input  wire bf5_pkg::vec_t                vec,
	input  wire logic [bf5_pkg::TAPS-1:0]     col_mask,
	output      logic [bf5_pkg::SUM_W-1:0]    sum
);

	bf5_pkg::vec_t win_q [bf5_pkg::TAPS];

	logic [bf5_pkg::SUM_W-1:0] col_sum [bf5_pkg::TAPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int m = 0; m < bf5_pkg::TAPS; m++) begin
				win_q[m] <= '0;
			end
		end else if (shift) begin
			for (int m = 0; m < bf5_pkg::TAPS - 1; m++) begin
				win_q[m] <= win_q[m + 1];
			end
			win_q[bf5_pkg::TAPS - 1] <= vec;
		end
	end

	always_comb begin
		for (int m = 0; m < bf5_pkg::TAPS; m++) begin
			col_sum[m] = '0;
			for (int j = 0; j < bf5_pkg::TAPS; j++) begin
				col_sum[m] = col_sum[m] + bf5_pkg::SUM_W'(win_q[m][j]);
			end
		end
	end

	always_comb begin
		sum = '0;
		for (int m = 0; m < bf5_pkg::TAPS; m++) begin
			if (col_mask[m]) begin
				sum = sum + col_sum[m];
			end
		end
	end

endmodule
`default_nettype wire

// ----- sv/bf5_scale.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bf5_scale
// Converts a window sum to the rounded 8.8 mean, sum * 256 / 25, using a
// reciprocal multiply that is exact over the whole sum range.
// ----------------------------------------------------------------------------
module bf5_scale (
	input  wire logic [bf5_pkg::SUM_W-1:0]  sum,
	output      logic [bf5_pkg::MEAN_W-1:0] mean
);

	localparam int XW    = bf5_pkg::SUM_W + 8;
	localparam int SHIFT = 26;
	localparam int RW    = 22;
	localparam int PW    = XW + RW;
	localparam logic [RW-1:0] RECIP      = 22'd2684355;
	localparam logic [XW-1:0] ROUND_BIAS = 21'd12;

	logic [XW-1:0] x;
	logic [PW-1:0] prod;

	assign x    = {sum, 8'd0} + ROUND_BIAS;
	assign prod = PW'(x) * PW'(RECIP);
	assign mean = prod[SHIFT +: bf5_pkg::MEAN_W];

endmodule
`default_nettype wire

// ----- sv/box_filter_5x5_zero_pad.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// box_filter_5x5_zero_pad
// Streaming 5x5 mean filter with zero padding over a square image.
// ----------------------------------------------------------------------------
// The block takes one transfer per clock unless stalled and presents each
// result in raster order; empty stages keep accepting while a finished
// result waits, until they fill. A pixel at raster index k makes the result
// of index k-2N-2 available; after the last pixel, 2N+2 flush transfers
// drain the remaining results, and flushes sent before the image is complete
// are ignored. The column history lives in one memory of MAX_SIZE words of
// four pixels, read and rewritten once per transfer, so the rate is one item
// per clock for every image size unless stalled. Writing image_size starts a
// new frame and must only be done while the block is idle.
// ----------------------------------------------------------------------------
module box_filter_5x5_zero_pad #(
	parameter int MAX_SIZE = 512
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output      logic                          cfg_ready,
	input  wire logic [bf5_pkg::SIZE_W-1:0]    image_size,
	input  wire logic                          src_valid,
	output      logic                          src_stall,
	input  wire logic                          operation,
	input  wire logic [bf5_pkg::PIX_W-1:0]     pixel_value,
	output      logic                          res_valid,
	input  wire logic                          res_stall,
	output      logic [bf5_pkg::MEAN_W-1:0]    mean_value,
	output      logic                          frame_last
);

	localparam int CW = $clog2(MAX_SIZE);
	localparam int WW = 4 * bf5_pkg::PIX_W;

	logic          src_acc;
	bf5_pkg::ctl_t info;
	logic [CW-1:0] rd_col;
	logic [WW-1:0] ram_rdata;
	logic [WW-1:0] rd_word;
	logic [WW-1:0] wr_word;
	bf5_pkg::vec_t vec;

	logic          v_s1;
	bf5_pkg::ctl_t info_s1;
	logic [CW-1:0] col_s1;
	logic          byp_s1;
	logic [WW-1:0] byp_word_s1;

	logic                       v_s2;
	logic [bf5_pkg::TAPS-1:0]   mask_s2;
	logic                       last_s2;
	logic [bf5_pkg::SUM_W-1:0]  win_sum;

	logic                       v_s3;
	logic [bf5_pkg::SUM_W-1:0]  sum_s3;
	logic                       last_s3;
	logic [bf5_pkg::MEAN_W-1:0] scaled;

	logic                       res_valid_q;
	logic [bf5_pkg::MEAN_W-1:0] mean_q;
	logic                       last_q;

	logic rdy2, rdy3, rdy4;
	logic go1, go2, go3;

	assign rdy4 = !res_valid_q || !res_stall;
	assign go3  = v_s3 && rdy4;
	assign rdy3 = !v_s3 || rdy4;
	assign go2  = v_s2 && rdy3;
	assign rdy2 = !v_s2 || rdy3;
	assign go1  = v_s1 && rdy2;

	assign src_stall = v_s1 && !rdy2;
	assign src_acc   = src_valid && !src_stall;
	assign cfg_ready = 1'b1;

	bf5_ctrl #(
		.MAX_SIZE(MAX_SIZE)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_valid),
		.cfg_size   (image_size),
		.acc        (src_acc),
		.operation  (operation),
		.pixel_value(pixel_value),
		.info       (info),
		.col        (rd_col)
	);

	bf5_ram #(
		.WIDTH(WW),
		.DEPTH(MAX_SIZE)
	) u_line_ram (
		.clk  (clk),
		.we   (go1),
		.waddr(col_s1),
		.wdata(wr_word),
		.re   (info.push),
		.raddr(rd_col),
		.rdata(ram_rdata)
	);

	// A read that meets the write of the same column in one cycle takes the
	// new word from the bypass register.
	assign rd_word = byp_s1 ? byp_word_s1 : ram_rdata;
	assign wr_word = {info_s1.value, rd_word[WW-1:bf5_pkg::PIX_W]};

	always_comb begin
		for (int j = 0; j < 4; j++) begin
			vec[j] = info_s1.row_mask[j] ? rd_word[j*bf5_pkg::PIX_W +: bf5_pkg::PIX_W] : '0;
		end
		vec[4] = info_s1.value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (!src_stall) begin
				v_s1 <= info.push;
			end
			if (rdy2) begin
				v_s2 <= go1 && info_s1.emit;
			end
			if (rdy3) begin
				v_s3 <= go2;
			end
			if (rdy4) begin
				res_valid_q <= go3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!src_stall) begin
			info_s1     <= info;
			col_s1      <= rd_col;
			byp_s1      <= go1 && (col_s1 == rd_col);
			byp_word_s1 <= wr_word;
		end
		if (rdy2) begin
			mask_s2 <= info_s1.col_mask;
			last_s2 <= info_s1.last;
		end
		if (rdy3) begin
			sum_s3  <= win_sum;
			last_s3 <= last_s2;
		end
		if (rdy4) begin
			mean_q <= scaled;
			last_q <= last_s3;
		end
	end

	bf5_window u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.shift   (go1),
		.vec     (vec),
		.col_mask(mask_s2),
		.sum     (win_sum)
	);

	bf5_scale u_scale (
		.sum (sum_s3),
		.mean(scaled)
	);

	assign res_valid  = res_valid_q;
	assign mean_value = mean_q;
	assign frame_last = last_q;

	a_window_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !rdy3) |=> $stable(win_sum))
		else $error("window changed while its result was waiting");

	a_sum_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !rdy4) |=> (v_s3 && $stable(sum_s3)))
		else $error("window sum lost while the output was stalled");

	a_mean_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (mean_value <= 16'hFF00))
		else $error("mean above the largest pixel value");

endmodule
`default_nettype wire
